[rtl/neighbor_fork_arbiter_defines.svh]
// Assertion macros shared by the neighbor fork arbiter modules.
`ifndef NEIGHBOR_FORK_ARBITER_DEFINES_SVH
`define NEIGHBOR_FORK_ARBITER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define NFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define NFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nfa_pkg.sv]
// Shared types and codes for the neighbor fork arbiter.
package nfa_pkg;

    localparam int SEAT_BITS = 6;

    localparam logic REQ_HUNGRY = 1'b0;
    localparam logic REQ_DONE   = 1'b1;

    localparam logic KIND_GRANT = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit2;
    } ctrl_cmd_t;

    typedef struct packed {
        logic two_grants;
    } dp_status_t;

endpackage

[rtl/nfa_datapath.sv]
// Datapath: resource and waiting bits, request decode and result registers.
`include "neighbor_fork_arbiter_defines.svh"

module nfa_datapath
    import nfa_pkg::*;
#(
    parameter int NUM_SEATS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic                 req_type,
    input  logic [SEAT_BITS-1:0] seat,
    output logic                 strobe,
    output logic                 kind,
    output logic [SEAT_BITS-1:0] granted_seat,
    output logic                 last
);

    localparam int IDX_W = (NUM_SEATS > 1) ? $clog2(NUM_SEATS) : 1;

    logic                 req_reg;
    logic [SEAT_BITS-1:0] seat_reg;
    logic [NUM_SEATS-1:0] busy_reg, busy_next;
    logic [NUM_SEATS-1:0] wait_reg, wait_next;
    logic [IDX_W-1:0]     pend_reg, pend_next;
    logic                 strobe_reg, strobe_next;
    logic                 kind_reg, kind_next;
    logic [SEAT_BITS-1:0] gseat_reg, gseat_next;
    logic                 last_reg, last_next;

    logic [IDX_W-1:0]     idx, nidx, pidx, lnext;
    logic                 in_range, is_error, hungry_free, right_ok, left_ok;
    logic [NUM_SEATS-1:0] need, busy_rel, busy_a, wait_a, busy_b, wait_b;

    function automatic logic [IDX_W-1:0] nxt_of(input logic [IDX_W-1:0] i);
        nxt_of = (i == IDX_W'(NUM_SEATS - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prv_of(input logic [IDX_W-1:0] i);
        prv_of = (i == '0) ? IDX_W'(NUM_SEATS - 1) : i - IDX_W'(1);
    endfunction

    function automatic logic [NUM_SEATS-1:0] one_hot(input logic [IDX_W-1:0] i);
        one_hot    = '0;
        one_hot[i] = 1'b1;
    endfunction

    always_comb
    begin
        idx         = seat_reg[IDX_W-1:0];
        nidx        = nxt_of(idx);
        pidx        = prv_of(idx);
        lnext       = nxt_of(nidx);
        in_range    = {1'b0, seat_reg} < (SEAT_BITS + 1)'(NUM_SEATS);
        is_error    = !in_range || (req_reg == REQ_HUNGRY && wait_reg[idx]);
        need        = one_hot(idx) | one_hot(nidx);
        hungry_free = (busy_reg & need) == '0;
        busy_rel    = busy_reg & ~need;
        right_ok    = wait_reg[pidx] && !busy_rel[pidx];
        busy_a      = right_ok ? (busy_rel | one_hot(pidx) | one_hot(idx)) : busy_rel;
        wait_a      = right_ok ? (wait_reg & ~one_hot(pidx)) : wait_reg;
        left_ok     = wait_a[nidx] && !busy_a[lnext];
        busy_b      = left_ok ? (busy_a | one_hot(nidx) | one_hot(lnext)) : busy_a;
        wait_b      = left_ok ? (wait_a & ~one_hot(nidx)) : wait_a;
    end

    assign status.two_grants = (req_reg == REQ_DONE) && !is_error && right_ok && left_ok;

    always_comb
    begin
        busy_next   = busy_reg;
        wait_next   = wait_reg;
        pend_next   = pend_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        gseat_next  = gseat_reg;
        last_next   = last_reg;
        if (cmd.exec)
        begin
            if (is_error)
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_ERROR;
                gseat_next  = seat_reg;
                last_next   = 1'b1;
            end
            else if (req_reg == REQ_HUNGRY)
            begin
                if (hungry_free)
                begin
                    busy_next   = busy_reg | need;
                    strobe_next = 1'b1;
                    kind_next   = KIND_GRANT;
                    gseat_next  = seat_reg;
                    last_next   = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg | one_hot(idx);
                end
            end
            else
            begin
                busy_next = busy_b;
                wait_next = wait_b;
                pend_next = nidx;
                if (right_ok)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_GRANT;
                    gseat_next  = SEAT_BITS'(pidx);
                    last_next   = !left_ok;
                end
                else if (left_ok)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_GRANT;
                    gseat_next  = SEAT_BITS'(nidx);
                    last_next   = 1'b1;
                end
            end
        end
        else if (cmd.emit2)
        begin
            strobe_next = 1'b1;
            kind_next   = KIND_GRANT;
            gseat_next  = SEAT_BITS'(pend_reg);
            last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            wait_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            wait_reg   <= wait_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            seat_reg <= seat;
        end
        pend_reg  <= pend_next;
        kind_reg  <= kind_next;
        gseat_reg <= gseat_next;
        last_reg  <= last_next;
    end

    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign granted_seat = gseat_reg;
    assign last         = last_reg;

    `NFA_ASSERT_NEXT(a_first_then_last, strobe_reg && !last_reg, strobe_reg && last_reg,
        "first of two grants not followed by the closing grant")
    `NFA_ASSERT_NOW(a_error_is_last, strobe_reg && kind_reg == KIND_ERROR, last_reg,
        "error word without last")
    `NFA_ASSERT_NEXT(a_no_word_after_load, cmd.load, !strobe_reg,
        "word emitted in the cycle after a request load")

endmodule

[rtl/nfa_ctrl.sv]
// Controller: request sequencing state machine.
`include "neighbor_fork_arbiter_defines.svh"

module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_SECOND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = status.two_grants ? S_SECOND : S_IDLE;
            end
            S_SECOND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cmd.load  = start && (state_reg == S_IDLE);
    assign cmd.exec  = (state_reg == S_EXEC);
    assign cmd.emit2 = (state_reg == S_SECOND);

    `NFA_ASSERT_NEXT(a_accept_to_exec, start && !busy, state_reg == S_EXEC,
        "accepted word did not enter execute")
    `NFA_ASSERT_NEXT(a_two_to_second, state_reg == S_EXEC && status.two_grants,
        state_reg == S_SECOND, "second grant not scheduled")
    `NFA_ASSERT_NEXT(a_second_ends, state_reg == S_SECOND, state_reg == S_IDLE,
        "second grant state did not return to idle")

endmodule

[rtl/neighbor_fork_arbiter.sv]
// Neighbor fork arbiter top level: controller plus datapath.
//
// Arbitrates a ring of NUM_SEATS seats; seat i needs resource i and
// resource i+1 (mod NUM_SEATS).
// Request channel: drive req_type (0 hungry, 1 done) and seat with start;
// the word is taken at a clock edge where start is high and busy is low.
// Result channel: strobe marks one cycle holding kind (0 grant, 1 error),
// granted_seat and last; last flags the final word of a request.
// A hungry request yields one grant, or nothing if it has to wait.
// A done request yields zero, one or two grants (right neighbor first).
// Errors: seat out of range, or hungry from a seat already waiting.
// Sequence: the request is decoded in the execute state, which registers the
// first word onto strobe; a done request that grants both neighbors emits
// its second word from the second-grant state. busy is high in both states,
// so no new request is taken until the arbiter is back in idle.
// Reset: all resources free, no seat waiting, strobe low, busy low.
// The receiver takes every word in its strobe cycle and cannot stall.
module neighbor_fork_arbiter
    import nfa_pkg::*;
#(
    parameter int NUM_SEATS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [SEAT_BITS-1:0] seat,
    output logic                 strobe,
    output logic                 kind,
    output logic [SEAT_BITS-1:0] granted_seat,
    output logic                 last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    nfa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    nfa_datapath #(
        .NUM_SEATS (NUM_SEATS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .seat         (seat),
        .strobe       (strobe),
        .kind         (kind),
        .granted_seat (granted_seat),
        .last         (last)
    );

endmodule

[tb/tb_neighbor_fork_arbiter.sv]
// Self-checking testbench for the neighbor fork arbiter: directed cases plus random traffic.
module tb_neighbor_fork_arbiter;
    import nfa_pkg::*;

    localparam int NUM_SEATS = 8;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic                 kind;
        logic [SEAT_BITS-1:0] seat;
        logic                 last;
    } arb_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic [SEAT_BITS-1:0] seat;
    logic                 strobe;
    logic                 kind;
    logic [SEAT_BITS-1:0] granted_seat;
    logic                 last;

    arb_word_t            grant_words[$];
    logic [NUM_SEATS-1:0] res_busy;
    logic [NUM_SEATS-1:0] seat_wait;
    logic [NUM_SEATS-1:0] seat_eating;
    bit                   gaps_on;
    int                   errors;

    neighbor_fork_arbiter #(.NUM_SEATS(NUM_SEATS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .seat         (seat),
        .strobe       (strobe),
        .kind         (kind),
        .granted_seat (granted_seat),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void push_word(logic k, int s, logic l);
        arb_word_t w;
        w.kind = k;
        w.seat = s[SEAT_BITS-1:0];
        w.last = l;
        grant_words.push_back(w);
    endfunction

    // Track resources and waiting seats; queue the words this request causes.
    function automatic void arbitrate(logic rt, logic [SEAT_BITS-1:0] s);
        int n;
        int nxt;
        int prv;
        int nn;
        int grants[$];
        n   = s;
        nxt = (n + 1) % NUM_SEATS;
        prv = (n + NUM_SEATS - 1) % NUM_SEATS;
        if (n >= NUM_SEATS)
        begin
            push_word(KIND_ERROR, n, 1'b1);
            return;
        end
        if (rt == REQ_HUNGRY && seat_wait[n])
        begin
            push_word(KIND_ERROR, n, 1'b1);
            return;
        end
        if (rt == REQ_HUNGRY)
        begin
            if (!res_busy[n] && !res_busy[nxt])
            begin
                res_busy[n]    = 1'b1;
                res_busy[nxt]  = 1'b1;
                seat_eating[n] = 1'b1;
                push_word(KIND_GRANT, n, 1'b1);
            end
            else
            begin
                seat_wait[n] = 1'b1;
            end
            return;
        end
        res_busy[n]    = 1'b0;
        res_busy[nxt]  = 1'b0;
        seat_eating[n] = 1'b0;
        if (seat_wait[prv] && !res_busy[prv])
        begin
            res_busy[prv]    = 1'b1;
            res_busy[n]      = 1'b1;
            seat_wait[prv]   = 1'b0;
            seat_eating[prv] = 1'b1;
            grants.push_back(prv);
        end
        nn = (nxt + 1) % NUM_SEATS;
        if (seat_wait[nxt] && !res_busy[nn])
        begin
            res_busy[nxt]    = 1'b1;
            res_busy[nn]     = 1'b1;
            seat_wait[nxt]   = 1'b0;
            seat_eating[nxt] = 1'b1;
            grants.push_back(nxt);
        end
        foreach (grants[i])
            push_word(KIND_GRANT, grants[i], i == grants.size() - 1);
    endfunction

    task automatic send_request(logic rt, logic [SEAT_BITS-1:0] s);
        bit idle;
        forever
        begin
            @(negedge clk);
            idle = gaps_on && ($urandom_range(99) < 38);
            if (idle)
            begin
                start <= 1'b0;
            end
            else
            begin
                start    <= 1'b1;
                req_type <= rt;
                seat     <= s;
            end
            @(posedge clk);
            if (!idle && !busy)
                break;
        end
        arbitrate(rt, s);
    endtask

    task automatic drain_words();
        @(negedge clk);
        start <= 1'b0;
        while (grant_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic issue_random_request();
        int  s;
        int  k;
        logic rt;
        if ($urandom_range(99) < 12)
        begin
            rt = 1'($urandom_range(1));
            s  = $urandom_range(63);
        end
        else
        begin
            s = $urandom_range(NUM_SEATS - 1);
            if (seat_eating[s])
                rt = REQ_DONE;
            else if (!seat_wait[s])
                rt = REQ_HUNGRY;
            else if ($urandom_range(99) < 20)
                rt = REQ_HUNGRY;
            else
            begin
                rt = REQ_DONE;
                if (seat_eating != '0)
                begin
                    do
                        k = $urandom_range(NUM_SEATS - 1);
                    while (!seat_eating[k]);
                    s = k;
                end
            end
        end
        send_request(rt, SEAT_BITS'(s));
    endtask

    task automatic test_directed_cases();
        gaps_on = 1'b0;
        send_request(REQ_HUNGRY, 0);
        send_request(REQ_HUNGRY, 7);
        send_request(REQ_HUNGRY, 7);
        send_request(REQ_HUNGRY, 8);
        send_request(REQ_DONE, 63);
        send_request(REQ_HUNGRY, 63);
        send_request(REQ_HUNGRY, 2);
        send_request(REQ_HUNGRY, 1);
        send_request(REQ_HUNGRY, 3);
        send_request(REQ_DONE, 2);
        send_request(REQ_DONE, 0);
        send_request(REQ_HUNGRY, 5);
        send_request(REQ_HUNGRY, 1);
        send_request(REQ_DONE, 6);
        send_request(REQ_DONE, 4);
        send_request(REQ_DONE, 1);
        send_request(REQ_HUNGRY, 1);
        send_request(REQ_DONE, 7);
        send_request(REQ_DONE, 3);
        send_request(REQ_HUNGRY, 0);
        send_request(REQ_DONE, 0);
        send_request(REQ_DONE, 1);
        send_request(REQ_DONE, 5);
        drain_words();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (300) issue_random_request();
        drain_words();
    endtask

    task automatic test_random_traffic();
        gaps_on = 1'b1;
        repeat (820) issue_random_request();
        drain_words();
    endtask

    task automatic test_release_all();
        gaps_on = 1'b1;
        for (int i = 0; i < NUM_SEATS; i++)
            send_request(REQ_DONE, SEAT_BITS'(i));
        drain_words();
    endtask

    always @(posedge clk)
    begin : check_words
        arb_word_t want;
        if (rst_n && strobe)
        begin
            if (grant_words.size() == 0)
            begin
                $error("unexpected word: kind=%0d granted_seat=%0d last=%0d",
                       kind, granted_seat, last);
                errors++;
            end
            else
            begin
                want = grant_words.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    errors++;
                end
                if (granted_seat !== want.seat)
                begin
                    $error("granted_seat: expected %0d, actual %0d", want.seat, granted_seat);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_HUNGRY;
        seat        = '0;
        res_busy    = '0;
        seat_wait   = '0;
        seat_eating = '0;
        gaps_on     = 1'b0;
        errors      = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed_cases();
        test_back_to_back();
        test_random_traffic();
        test_release_all();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/nfa_pkg.sv
rtl/nfa_datapath.sv
rtl/nfa_ctrl.sv
rtl/neighbor_fork_arbiter.sv
tb/tb_neighbor_fork_arbiter.sv
